[hdl/slls_pkg.sv]
package slls_pkg;

  localparam int SLOTS    = 8;
  localparam int TAG_BITS = 8;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  // search word that travels down the row, one cell per cycle
  typedef struct packed {
    logic                valid;
    logic                is_read;
    logic [SLOT_W-1:0]   key;
    logic                hit;
    logic [SLOT_W-1:0]   hit_idx;
    logic [TAG_BITS-1:0] tag;
  } probe_t;

  // broadcast command from the controller to every cell
  typedef struct packed {
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_idx;
    logic [SLOT_W-1:0]   wr_slot;
    logic [TAG_BITS-1:0] wr_tag;
    logic                sh_en;
    logic [SLOT_W-1:0]   sh_idx;
  } cell_cmd_t;

endpackage

[hdl/slls_cell.sv]
module slls_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [slls_pkg::SLOT_W-1:0]   cell_idx,
  input  logic [slls_pkg::CNT_W-1:0]    count,
  input  slls_pkg::cell_cmd_t           cmd,
  input  logic [slls_pkg::SLOT_W-1:0]   nbr_slot,
  input  logic [slls_pkg::TAG_BITS-1:0] nbr_tag,
  input  slls_pkg::probe_t              probe_in,
  output slls_pkg::probe_t              probe_out,
  output logic [slls_pkg::SLOT_W-1:0]   slot_q,
  output logic [slls_pkg::TAG_BITS-1:0] tag_q
);
  import slls_pkg::*;

  // cell i holds the entry at list position i
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  probe_t              probe_r, probe_nxt;
  logic                match;

  always_comb begin
    slot_nxt = slot_r;
    tag_nxt  = tag_r;
    if (cmd.wr_en && cell_idx == cmd.wr_idx) begin
      slot_nxt = cmd.wr_slot;
      tag_nxt  = cmd.wr_tag;
    end else if (cmd.sh_en && cell_idx >= cmd.sh_idx) begin
      // close the gap: take the entry one position further along
      slot_nxt = nbr_slot;
      tag_nxt  = nbr_tag;
    end
  end

  always_comb begin
    match = (CNT_W'(cell_idx) < count) &&
            (probe_in.is_read ? (cell_idx == probe_in.key) : (slot_r == probe_in.key));
    probe_nxt = probe_in;
    if (probe_in.valid && !probe_in.hit && match) begin
      probe_nxt.hit     = 1'b1;
      probe_nxt.hit_idx = cell_idx;
      probe_nxt.tag     = tag_r;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    tag_r  <= tag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.valid <= 1'b0;
    end else begin
      probe_r.valid <= probe_nxt.valid;
    end
    probe_r.is_read <= probe_nxt.is_read;
    probe_r.key     <= probe_nxt.key;
    probe_r.hit     <= probe_nxt.hit;
    probe_r.hit_idx <= probe_nxt.hit_idx;
    probe_r.tag     <= probe_nxt.tag;
  end

  assign probe_out = probe_r;
  assign slot_q    = slot_r;
  assign tag_q     = tag_r;

endmodule

[hdl/slot_linked_list_store_top.sv]
// Channel  Dir  Handshake             Word fields (low bit up)
// in_      in   in_tvalid/in_tready   op, item_tag, slot_sel, list_pos
// out_     out  out_tvalid/out_tready status, slot_out, tag_out, held_count
//
// Append and every rejected request go from S_IDLE straight to S_DONE, which loads out_tvalid.
// Remove and read pass through S_WALK; a search word walks the row of list cells
// one cell per cycle, and a remove then closes the gap by shifting the later cells down.
// One request is in flight at a time; a new one is taken while the last result
// still waits in the output register. A stalled output holds its word.
// Reset (rst_n low, synchronous) empties the list at once.
module slot_linked_list_store_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op[1:0], item_tag[9:2], slot_sel[12:10], list_pos[15:13]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status[1:0], slot_out[4:2], tag_out[12:5],
                                  // held_count[16:13], zero fill
);
  import slls_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SLOTS-1:0]    used_r, used_nxt;
  logic                launch_r, launch_nxt;
  logic                is_read_r, is_read_nxt;
  logic [SLOT_W-1:0]   key_r, key_nxt;
  logic [SLOT_W-1:0]   sel_r, sel_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic [2:0]          res_slot_r, res_slot_nxt;
  logic [7:0]          res_tag_r, res_tag_nxt;
  logic [3:0]          res_count_r, res_count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [23:0]         out_tdata_r, out_tdata_nxt;

  op_t                 op;
  logic [7:0]          item_tag;
  logic [2:0]          slot_sel;
  logic [2:0]          list_pos;
  logic                accept;
  logic                out_free;
  logic                free_found;
  logic [SLOT_W-1:0]   free_slot;
  logic                sel_ok;
  cell_cmd_t           cmd;
  probe_t              probe_w [0:SLOTS];
  logic [SLOT_W-1:0]   slot_w [0:SLOTS];
  logic [TAG_BITS-1:0] tag_w [0:SLOTS];
  probe_t              walk_res;

  assign op       = op_t'(in_tdata[1:0]);
  assign item_tag = in_tdata[9:2];
  assign slot_sel = in_tdata[12:10];
  assign list_pos = in_tdata[15:13];
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign walk_res = probe_w[SLOTS];

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  assign sel_ok = (int'(slot_sel) < SLOTS) && used_r[SLOT_W'(slot_sel)] && (count_r != '0);

  // row of list cells
  assign probe_w[0] = '{valid: launch_r, is_read: is_read_r, key: key_r,
                        hit: 1'b0, hit_idx: '0, tag: '0};
  assign slot_w[SLOTS] = '0;
  assign tag_w[SLOTS]  = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    slls_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (SLOT_W'(g)),
      .count     (count_r),
      .cmd       (cmd),
      .nbr_slot  (slot_w[g+1]),
      .nbr_tag   (tag_w[g+1]),
      .probe_in  (probe_w[g]),
      .probe_out (probe_w[g+1]),
      .slot_q    (slot_w[g]),
      .tag_q     (tag_w[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if ((op == OP_REMOVE && sel_ok) ||
              (op == OP_READ && CNT_W'(list_pos) < count_r)) begin
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_WALK: begin
        if (walk_res.valid) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_tready      = (state_r == S_IDLE);
    count_nxt      = count_r;
    used_nxt       = used_r;
    launch_nxt     = 1'b0;
    is_read_nxt    = is_read_r;
    key_nxt        = key_r;
    sel_nxt        = sel_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_tag_nxt    = res_tag_r;
    res_count_nxt  = res_count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    cmd            = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = ST_MISS;
          res_slot_nxt   = '0;
          res_tag_nxt    = '0;
          res_count_nxt  = 4'(count_r);
          case (op)
            OP_APPEND: begin
              if (count_r >= CNT_W'(SLOTS) || !free_found) begin
                res_status_nxt = ST_FULL;
              end else begin
                cmd.wr_en          = 1'b1;
                cmd.wr_idx         = SLOT_W'(count_r);
                cmd.wr_slot        = free_slot;
                cmd.wr_tag         = TAG_BITS'(item_tag);
                used_nxt[free_slot] = 1'b1;
                count_nxt          = count_r + 1'b1;
                res_status_nxt     = ST_OK;
                res_slot_nxt       = 3'(free_slot);
                res_count_nxt      = 4'(count_r + 1'b1);
              end
            end
            OP_REMOVE: begin
              if (sel_ok) begin
                launch_nxt  = 1'b1;
                is_read_nxt = 1'b0;
                key_nxt     = SLOT_W'(slot_sel);
                sel_nxt     = SLOT_W'(slot_sel);
              end
            end
            OP_READ: begin
              if (CNT_W'(list_pos) < count_r) begin
                launch_nxt  = 1'b1;
                is_read_nxt = 1'b1;
                key_nxt     = SLOT_W'(list_pos);
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (walk_res.valid) begin
          res_status_nxt = ST_MISS;
          res_slot_nxt   = '0;
          res_tag_nxt    = '0;
          res_count_nxt  = 4'(count_r);
          if (walk_res.hit) begin
            res_status_nxt = ST_OK;
            if (is_read_r) begin
              res_tag_nxt = 8'(walk_res.tag);
            end else begin
              cmd.sh_en       = 1'b1;
              cmd.sh_idx      = walk_res.hit_idx;
              used_nxt[sel_r] = 1'b0;
              count_nxt       = count_r - 1'b1;
              res_count_nxt   = 4'(count_r - 1'b1);
            end
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = {7'd0, res_count_r, res_tag_r, res_slot_r, res_status_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      used_r      <= '0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_read_r    <= is_read_nxt;
    key_r        <= key_nxt;
    sel_r        <= sel_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_tag_r    <= res_tag_nxt;
    res_count_r  <= res_count_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOTS))
    else $error("entry count beyond pool size");

  a_used_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(count_r))
    else $error("occupancy bits disagree with entry count");

  a_walk_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    walk_res.valid |-> state_r == S_WALK)
    else $error("search word left the row outside a walk");

  a_shift_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sh_en |=> count_r == $past(count_r) - 1'b1)
    else $error("remove did not lower the entry count");

endmodule

[bench/list_store_checker.sv]
`timescale 1ns / 1ps

module list_store_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // op[1:0], item_tag[9:2], slot_sel[12:10], list_pos[15:13]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // status[1:0], slot_out[4:2], tag_out[12:5],
                                  // held_count[16:13], zero fill
  output int          fail_count,
  output int          pending_words
);
  import slls_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [TAG_BITS-1:0] tag;
    logic [CNT_W-1:0]    held;
  } reply_t;

  // shadow copy of the list
  logic [TAG_BITS-1:0] tags  [SLOTS];
  logic [SLOT_W-1:0]   links [SLOTS];
  logic                used  [SLOTS];
  int                  head;
  int                  tail;
  int                  count;

  reply_t awaited_replies [$];
  reply_t want;
  int     errs;

  function automatic reply_t apply_request(op_t op, logic [TAG_BITS-1:0] tag_in,
                                           logic [SLOT_W-1:0] sel,
                                           logic [SLOT_W-1:0] pos);
    reply_t r;
    int     s;
    int     p;
    int     i;
    bit     found;
    r.status = ST_MISS;
    r.slot   = '0;
    r.tag    = '0;
    case (op)
      OP_APPEND: begin
        found = 0;
        s = 0;
        for (i = 0; i < SLOTS; i++)
          if (!found && !used[i]) begin
            found = 1;
            s = i;
          end
        if (!found || count >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          tags[s]  = tag_in;
          links[s] = '0;
          used[s]  = 1'b1;
          if (count == 0) head = s;
          else links[tail] = SLOT_W'(s);
          tail = s;
          count++;
          r.status = ST_OK;
          r.slot   = SLOT_W'(s);
        end
      end
      OP_REMOVE: begin
        s = sel;
        if (used[s] && count != 0) begin
          if (s == head) begin
            head = links[s];
            r.status = ST_OK;
          end else begin
            // find the predecessor, never following the tail's link
            p = head;
            found = 0;
            for (i = 0; i + 1 < count; i++)
              if (!found) begin
                if (links[p] == s) found = 1;
                else p = links[p];
              end
            if (found) begin
              links[p] = links[s];
              if (s == tail) tail = p;
              r.status = ST_OK;
            end
          end
          if (r.status == ST_OK) begin
            used[s] = 1'b0;
            count--;
            if (count == 0) begin
              head = 0;
              tail = 0;
            end
          end
        end
      end
      OP_READ: begin
        if (pos < count) begin
          p = head;
          for (i = 0; i < pos; i++) p = links[p];
          r.status = ST_OK;
          r.tag    = tags[p];
        end
      end
      default: r.status = ST_MISS;
    endcase
    r.held = CNT_W'(count);
    return r;
  endfunction

  task automatic check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      errs++;
    end
  endtask

  initial begin
    errs = 0;
    fail_count = 0;
    pending_words = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SLOTS; k++) begin
        tags[k]  = '0;
        links[k] = '0;
        used[k]  = 1'b0;
      end
      head = 0;
      tail = 0;
      count = 0;
      awaited_replies.delete();
    end else begin
      // pop before push: a word leaving now belongs to an earlier request
      if (out_tvalid && out_tready) begin
        if (awaited_replies.size() == 0) begin
          $error("unexpected output word %h", out_tdata);
          errs++;
        end else begin
          want = awaited_replies.pop_front();
          check_field("status", want.status, out_tdata[1:0]);
          check_field("slot_out", want.slot, out_tdata[4:2]);
          check_field("tag_out", want.tag, out_tdata[12:5]);
          check_field("held_count", want.held, out_tdata[16:13]);
          check_field("zero fill", 0, out_tdata[23:17]);
        end
      end
      if (in_tvalid && in_tready)
        awaited_replies.push_back(apply_request(op_t'(in_tdata[1:0]), in_tdata[9:2],
                                                in_tdata[12:10], in_tdata[15:13]));
    end
    fail_count    <= errs;
    pending_words <= awaited_replies.size();
  end

endmodule

[bench/slot_linked_list_store_top_tb.sv]
`timescale 1ns / 1ps

module slot_linked_list_store_top_tb;
  import slls_pkg::*;

  localparam int RANDOM_WORDS = 1400;
  localparam int HOLD_CYCLES  = 300;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // op[1:0], item_tag[9:2], slot_sel[12:10], list_pos[15:13]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // status[1:0], slot_out[4:2], tag_out[12:5],
                           // held_count[16:13], zero fill
  int          fail_count;
  int          pending_words;

  bit gap_on;
  bit stall_on;
  int hold_req;

  slot_linked_list_store_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  list_store_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_req(op_t op, logic [TAG_BITS-1:0] tag, logic [SLOT_W-1:0] sel,
                          logic [SLOT_W-1:0] pos);
    while (gap_on && $urandom_range(0, 99) < 34) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pos, sel, tag, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: random stalls, plus long hold-offs on request
  initial begin : sink
    int seen;
    seen = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != seen) begin
        seen++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_tready <= !(stall_on && $urandom_range(0, 99) < 34);
      end
    end
  end

  initial begin : stimulus
    int  n;
    int  r;
    int  phase;
    int  phase_left;
    op_t op;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    rst_n     = 1'b0;
    gap_on    = 1'b1;
    stall_on  = 1'b1;
    hold_req  = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list
    send_req(OP_READ,   8'h00, 3'd0, 3'd0);
    send_req(OP_REMOVE, 8'h00, 3'd0, 3'd0);
    send_req(OP_NONE,   8'hFF, 3'd7, 3'd7);
    // fill every slot, tags at the extremes
    send_req(OP_APPEND, 8'h00, 3'd7, 3'd7);
    send_req(OP_APPEND, 8'hFF, 3'd0, 3'd0);
    send_req(OP_APPEND, 8'hA5, 3'd5, 3'd2);
    send_req(OP_APPEND, 8'h5A, 3'd2, 3'd5);
    send_req(OP_APPEND, 8'h01, 3'd1, 3'd6);
    send_req(OP_APPEND, 8'h80, 3'd6, 3'd1);
    send_req(OP_APPEND, 8'h7F, 3'd3, 3'd4);
    send_req(OP_APPEND, 8'hFE, 3'd4, 3'd3);
    send_req(OP_APPEND, 8'h33, 3'd0, 3'd0);   // pool full
    send_req(OP_READ,   8'h00, 3'd0, 3'd7);
    // head, middle, tail, then an already free slot
    send_req(OP_REMOVE, 8'h00, 3'd0, 3'd0);
    send_req(OP_REMOVE, 8'h00, 3'd4, 3'd0);
    send_req(OP_REMOVE, 8'h00, 3'd7, 3'd0);
    send_req(OP_REMOVE, 8'h00, 3'd4, 3'd0);
    send_req(OP_READ,   8'h00, 3'd0, 3'd5);   // past the end
    send_req(OP_READ,   8'h00, 3'd0, 3'd4);
    // drain to empty, then start a fresh list
    send_req(OP_REMOVE, 8'h00, 3'd3, 3'd0);
    send_req(OP_REMOVE, 8'h00, 3'd6, 3'd0);
    send_req(OP_REMOVE, 8'h00, 3'd1, 3'd0);
    send_req(OP_REMOVE, 8'h00, 3'd5, 3'd0);
    send_req(OP_REMOVE, 8'h00, 3'd2, 3'd0);
    send_req(OP_APPEND, 8'hC3, 3'd0, 3'd0);
    send_req(OP_READ,   8'h00, 3'd0, 3'd0);

    // random part: fill-heavy, drain-heavy and mixed phases
    n = 0;
    phase = 0;
    phase_left = 0;
    while (n < RANDOM_WORDS) begin
      if (phase_left == 0) begin
        phase = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      gap_on   = !(n >= 400 && n < 650);
      stall_on = gap_on;
      if (n == 800 && hold_req == 0) hold_req = 1;
      r = $urandom_range(0, 99);
      case (phase)
        0:       op = (r < 55) ? OP_APPEND : (r < 75) ? OP_REMOVE :
                      (r < 97) ? OP_READ : OP_NONE;
        1:       op = (r < 15) ? OP_APPEND : (r < 70) ? OP_REMOVE :
                      (r < 97) ? OP_READ : OP_NONE;
        default: op = (r < 33) ? OP_APPEND : (r < 63) ? OP_REMOVE :
                      (r < 97) ? OP_READ : OP_NONE;
      endcase
      send_req(op, TAG_BITS'($urandom_range(0, 255)), SLOT_W'($urandom_range(0, 7)),
               SLOT_W'($urandom_range(0, 7)));
      if (op != OP_NONE) n++;
    end
    in_tvalid <= 1'b0;

    while (pending_words != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
hdl/slls_pkg.sv
hdl/slls_cell.sv
hdl/slot_linked_list_store_top.sv
bench/list_store_checker.sv
bench/slot_linked_list_store_top_tb.sv
